### rtl/crc8_checked_packet_receiver_assert.svh
// Assertion macros shared by the packet receiver front and queue modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef CRC8_CHECKED_PACKET_RECEIVER_ASSERT_SVH
`define CRC8_CHECKED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRC8R_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc8r assertion failed");

// Next-cycle implication, checked outside reset.
`define CRC8R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc8r assertion failed");

`endif

### rtl/crc8r_pkg.sv
// Package for the CRC-8 checked packet receiver: types, constants, CRC function.
// No dependencies.
`timescale 1ns / 1ps
package crc8r_pkg;

  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [7:0] CRC_INIT       = 8'h00;
  localparam int         STORE_DEPTH    = 12;
  localparam int         PAYLOAD_BYTES  = 11;
  localparam logic [3:0] STORE_LIMIT    = 4'd12;
  localparam logic [3:0] COUNT_MAX      = 4'd13;
  localparam logic [3:0] CRC_SNAP_COUNT = 4'd8;
  localparam logic [3:0] AIM_LEN        = 4'd10;
  localparam logic [3:0] MOTION_LEN     = 4'd12;
  localparam int         QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] STATUS_AIM_OK    = 2'd0;
  localparam logic [1:0] STATUS_MOTION_OK = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR   = 2'd2;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd3;

  typedef enum logic [1:0] {
    KIND_AIM     = 2'd0,
    KIND_MOTION  = 2'd1,
    KIND_LEN_ERR = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [7:0]  user_value;
    logic [7:0]  shoot_value;
    logic [7:0]  mode_value;
    logic [1:0]  auto_mode;
    logic        fire_flag;
    logic [7:0]  crc_received;
    logic [7:0]  crc_computed;
  } result_t;

  // Classified packet handed from the front to the back.
  typedef struct packed {
    frame_kind_t                        kind;
    logic                               crc_ok;
    logic [7:0]                         crc_received;
    logic [7:0]                         crc_computed;
    logic [PAYLOAD_BYTES-1:0][7:0]      payload;
  } frame_t;

  // CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/crc8r_front.sv
// Front part: takes bytes, runs the CRC, stores the payload, classifies packets.
// Depends on crc8r_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "crc8_checked_packet_receiver_assert.svh"
module crc8r_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  crc8r_pkg::rx_item_t item,
  output logic                push,
  output crc8r_pkg::frame_t   frame
);
  import crc8r_pkg::*;

  logic [3:0] count_r, count_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] crc9_r, crc9_nxt;
  logic [7:0] store_r [STORE_DEPTH];
  logic [7:0] crc_new;
  logic [3:0] length;

  assign crc_new = crc8_update(crc_r, item.rx_byte);
  assign length  = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 4'd1;
  assign push    = acc && item.last_byte;

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    crc9_nxt  = crc9_r;
    if (acc) begin
      count_nxt = length;
      crc_nxt   = crc_new;
      if (count_r == CRC_SNAP_COUNT) crc9_nxt = crc_new;
      // end of packet: start the next one clean
      if (item.last_byte) begin
        count_nxt = 4'd0;
        crc_nxt   = CRC_INIT;
        crc9_nxt  = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      crc_r   <= CRC_INIT;
      crc9_r  <= CRC_INIT;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      crc9_r  <= crc9_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (count_r < STORE_LIMIT)) store_r[count_r] <= item.rx_byte;
  end

  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) frame.payload[i] = store_r[i];
    frame.crc_received = item.rx_byte;
    if (length == AIM_LEN) begin
      frame.kind         = KIND_AIM;
      frame.crc_computed = crc9_r;
    end else if (length == MOTION_LEN) begin
      frame.kind         = KIND_MOTION;
      frame.crc_computed = crc_r;
    end else begin
      frame.kind         = KIND_LEN_ERR;
      frame.crc_computed = crc_r;
    end
    frame.crc_ok = (frame.crc_computed == item.rx_byte);
  end

  `CRC8R_ASSERT_NEXT(a_count_clears_at_end, push, count_r == 4'd0)
  `CRC8R_ASSERT_NOW(a_count_saturates, 1'b1, count_r <= COUNT_MAX)

endmodule

### rtl/crc8r_queue.sv
// Short queue of classified packets between front and back.
// Depends on crc8r_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "crc8_checked_packet_receiver_assert.svh"
module crc8r_queue #(
  parameter int DEPTH = crc8r_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  crc8r_pkg::frame_t wr_data,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output crc8r_pkg::frame_t rd_data
);
  import crc8r_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `CRC8R_ASSERT_NOW(a_no_overflow, push, !full)
  `CRC8R_ASSERT_NEXT(a_pop_drains, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

### rtl/crc8r_back.sv
// Back part: turns a classified packet into a result and holds it in the output register.
// Depends on crc8r_pkg.
`timescale 1ns / 1ps
module crc8r_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  crc8r_pkg::frame_t  q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output crc8r_pkg::result_t out_data
);
  import crc8r_pkg::*;

  result_t res;
  result_t out_r;
  logic    out_valid_r;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    res = '0;
    unique case (q_data.kind)
      KIND_AIM: begin
        res.status       = q_data.crc_ok ? STATUS_AIM_OK : STATUS_CRC_ERR;
        res.word_first   = {q_data.payload[3], q_data.payload[2],
                            q_data.payload[1], q_data.payload[0]};
        res.word_second  = {q_data.payload[7], q_data.payload[6],
                            q_data.payload[5], q_data.payload[4]};
        res.user_value   = q_data.payload[8];
        res.auto_mode    = q_data.crc_ok ? q_data.payload[8][7:6] : 2'd0;
        res.fire_flag    = q_data.crc_ok && q_data.payload[8][5];
        res.crc_received = q_data.crc_received;
        res.crc_computed = q_data.crc_computed;
      end
      KIND_MOTION: begin
        res.status       = q_data.crc_ok ? STATUS_MOTION_OK : STATUS_CRC_ERR;
        res.word_first   = {q_data.payload[3], q_data.payload[2],
                            q_data.payload[1], q_data.payload[0]};
        res.word_second  = {q_data.payload[7], q_data.payload[6],
                            q_data.payload[5], q_data.payload[4]};
        res.user_value   = q_data.payload[10];
        res.shoot_value  = q_data.payload[8];
        res.mode_value   = q_data.payload[9];
        res.crc_received = q_data.crc_received;
        res.crc_computed = q_data.crc_computed;
      end
      default: begin
        res.status = STATUS_LEN_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_r <= res;
  end

endmodule

### rtl/crc8_checked_packet_receiver.sv
// Top level of the CRC-8 checked packet receiver (polynomial 0x07, init 0x00).
// Depends on crc8r_pkg, crc8r_front, crc8r_queue and crc8r_back.
//
//   channel | ports                          | moves
//   --------+--------------------------------+----------------------------------
//   input   | in_valid, in_ready, in_data    | one packet byte plus last flag
//   result  | out_valid, out_ready, out_data | one status/field record per packet
//
// Cycles: one byte per cycle sustained while the packet queue is not full; the
//   CRC update is an 8-step XOR network finished in the accept cycle.
// Path: the edge that accepts a packet's last byte pushes it into the packet
//   queue; it is loaded into the output register once that register is empty
//   or its result is taken.
// Reset: synchronous, active low; clears byte count, CRCs, queue pointers and
//   out_valid. The byte store needs no reset: only bytes of the current packet
//   are read.
// Stalls: in_ready drops only while the packet queue (QUEUE_DEPTH entries) is
//   full; the output register refills in the same cycle its result is taken.
`timescale 1ns / 1ps
module crc8_checked_packet_receiver #(
  parameter int QUEUE_DEPTH = crc8r_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crc8r_pkg::rx_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crc8r_pkg::result_t out_data
);
  import crc8r_pkg::*;

  logic   in_acc;
  logic   q_push, q_full, q_pop, q_valid;
  frame_t front_frame, q_frame;

  // Hold off new bytes only while the queue cannot take a finished packet.
  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  // Front: count, CRC, store and classify each packet.
  crc8r_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .item  (in_data),
    .push  (q_push),
    .frame (front_frame)
  );

  // Queue: decouple packet classification from result delivery.
  crc8r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (front_frame),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_frame)
  );

  // Back: format the result and hold it until the result is taken.
  crc8r_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_frame),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/crc8_checked_packet_receiver_tb.sv
// Self-checking bench for crc8_checked_packet_receiver: aim, motion, bad-length and bad-CRC
// packets, random stalls on both channels, results checked against a scoreboard.
// Depends on crc8r_pkg and the receiver RTL.
`timescale 1ns / 1ps

// Tracks the receiver's packet state and holds the results each finished packet must produce.
class packet_scoreboard_t;
  logic [3:0] byte_cnt = '0;
  logic [7:0] crc_run = '0;
  logic [7:0] crc_nine = '0;
  logic [7:0] held_bytes[crc8r_pkg::STORE_DEPTH];
  crc8r_pkg::result_t frames_due[$];
  int errors = 0;

  // Bit-serial CRC-8, polynomial 0x07, MSB first.
  function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return c;
  endfunction

  function logic [31:0] word_from(input int base);
    return {held_bytes[base + 3], held_bytes[base + 2], held_bytes[base + 1], held_bytes[base]};
  endfunction

  // Advance the packet state by one accepted request; queue a result on the last byte.
  function void note_request(input crc8r_pkg::rx_item_t req);
    logic [3:0] cnt;
    logic [7:0] crc_prev;
    logic ok;
    crc8r_pkg::result_t res;
    cnt = byte_cnt;
    if (cnt < crc8r_pkg::STORE_LIMIT) held_bytes[cnt] = req.rx_byte;
    crc_prev = crc_run;
    crc_run = crc_step(crc_run, req.rx_byte);
    if (cnt == crc8r_pkg::CRC_SNAP_COUNT) crc_nine = crc_run;
    byte_cnt = (cnt == crc8r_pkg::COUNT_MAX) ? cnt : cnt + 4'd1;
    if (!req.last_byte) return;
    res = '0;
    if (byte_cnt == crc8r_pkg::AIM_LEN) begin
      ok = (crc_nine == req.rx_byte);
      res.status = ok ? crc8r_pkg::STATUS_AIM_OK : crc8r_pkg::STATUS_CRC_ERR;
      res.word_first = word_from(0);
      res.word_second = word_from(4);
      res.user_value = held_bytes[8];
      res.auto_mode = ok ? held_bytes[8][7:6] : 2'd0;
      res.fire_flag = ok ? held_bytes[8][5] : 1'b0;
      res.crc_received = req.rx_byte;
      res.crc_computed = crc_nine;
    end else if (byte_cnt == crc8r_pkg::MOTION_LEN) begin
      ok = (crc_prev == req.rx_byte);
      res.status = ok ? crc8r_pkg::STATUS_MOTION_OK : crc8r_pkg::STATUS_CRC_ERR;
      res.word_first = word_from(0);
      res.word_second = word_from(4);
      res.user_value = held_bytes[10];
      res.shoot_value = held_bytes[8];
      res.mode_value = held_bytes[9];
      res.crc_received = req.rx_byte;
      res.crc_computed = crc_prev;
    end else begin
      res.status = crc8r_pkg::STATUS_LEN_ERR;
    end
    frames_due.push_back(res);
    byte_cnt = '0;
    crc_run = '0;
    crc_nine = '0;
  endfunction

  function void field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare an accepted result against the oldest outstanding packet.
  function void check_result(input crc8r_pkg::result_t got);
    crc8r_pkg::result_t want;
    if (frames_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = frames_due.pop_front();
    field_check("status", 32'(want.status), 32'(got.status));
    field_check("word_first", want.word_first, got.word_first);
    field_check("word_second", want.word_second, got.word_second);
    field_check("user_value", 32'(want.user_value), 32'(got.user_value));
    field_check("shoot_value", 32'(want.shoot_value), 32'(got.shoot_value));
    field_check("mode_value", 32'(want.mode_value), 32'(got.mode_value));
    field_check("auto_mode", 32'(want.auto_mode), 32'(got.auto_mode));
    field_check("fire_flag", 32'(want.fire_flag), 32'(got.fire_flag));
    field_check("crc_received", 32'(want.crc_received), 32'(got.crc_received));
    field_check("crc_computed", 32'(want.crc_computed), 32'(got.crc_computed));
  endfunction
endclass

module crc8_checked_packet_receiver_tb;
  import crc8r_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  localparam int TARGET_REQUESTS = 1200;

  typedef enum {
    PK_AIM,
    PK_AIM_BADCRC,
    PK_MOTION,
    PK_MOTION_BADCRC,
    PK_BADLEN
  } pkt_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rx_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;

  // Set during a stretch where neither side may idle.
  bit steady = 1'b0;
  int sent = 0;
  int stall_cycles = 0;

  packet_scoreboard_t sb = new();

  crc8_checked_packet_receiver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random, with a chance of about 29 in 100, except in the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 29);
  end

  // Watch both channels: feed accepted requests to the scoreboard, check results,
  // and stop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: watchdog expired, %0d results outstanding", $time,
                   sb.frames_due.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Present one request and hold it until accepted. Idle first at random; valid is
  // lowered only when a gap is taken, so it never toggles within one step.
  task automatic send_request(input logic [7:0] data, input logic is_last);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 29) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{rx_byte: data, last_byte: is_last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold off the sender until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.frames_due.size() != 0);
  endtask

  // Build one packet and send it. fill >= 0 sets every payload byte to that value;
  // drain_at names the byte before which the sender waits for all results.
  task automatic send_packet(input pkt_kind_t kind, input int fill, input int drain_at);
    logic [7:0] body[$];
    logic [7:0] crc;
    int len;
    unique case (kind)
      PK_AIM, PK_AIM_BADCRC: len = 9;
      PK_MOTION, PK_MOTION_BADCRC: len = 11;
      default: begin
        // Any length but the two valid ones, overlong included.
        do len = $urandom_range(1, 20); while (len == AIM_LEN || len == MOTION_LEN);
      end
    endcase
    crc = CRC_INIT;
    for (int k = 0; k < len; k++) begin
      body.push_back((fill >= 0) ? fill[7:0] : 8'($urandom_range(255)));
      crc = sb.crc_step(crc, body[k]);
    end
    if (kind == PK_AIM || kind == PK_MOTION) body.push_back(crc);
    if (kind == PK_AIM_BADCRC || kind == PK_MOTION_BADCRC) begin
      body.push_back(crc ^ 8'($urandom_range(1, 255)));
    end
    for (int k = 0; k < body.size(); k++) begin
      if (k == drain_at) drain_results();
      send_request(body[k], k == body.size() - 1);
    end
  endtask

  // Random bytes with random end marks: mostly short bad-length frames.
  task automatic send_noise();
    int n;
    logic is_last;
    n = $urandom_range(1, 24);
    for (int k = 0; k < n; k++) begin
      is_last = (k == n - 1) || ($urandom_range(7) == 0);
      send_request(8'($urandom_range(255)), is_last);
      if (is_last) break;
    end
  endtask

  initial begin
    int pkt;
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a one-byte frame, an all-ones aim packet with good CRC (auto mode 3,
    // fire flag set), and an all-zero motion packet with a corrupted CRC.
    send_request(8'hFF, 1'b1);
    send_packet(PK_AIM, 8'hFF, -1);
    send_packet(PK_MOTION_BADCRC, 8'h00, -1);
    drain_results();

    // Random: mostly well-formed packets with random content, plus bad CRCs,
    // bad lengths and noise. Drain mid-packet now and then.
    pkt = 0;
    while (sent < TARGET_REQUESTS) begin
      steady = (pkt >= 30 && pkt < 70);
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_packet(PK_AIM, -1, (pkt % 40 == 17) ? $urandom_range(1, 8) : -1);
      end else if (pick < 40) begin
        send_packet(PK_AIM_BADCRC, -1, -1);
      end else if (pick < 65) begin
        send_packet(PK_MOTION, -1, (pkt % 40 == 23) ? $urandom_range(1, 10) : -1);
      end else if (pick < 75) begin
        send_packet(PK_MOTION_BADCRC, -1, -1);
      end else if (pick < 88) begin
        send_packet(PK_BADLEN, -1, -1);
      end else begin
        send_noise();
      end
      pkt++;
    end
    steady = 1'b0;

    // Let the last results drain before the final check.
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.frames_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/crc8r_pkg.sv
rtl/crc8r_front.sv
rtl/crc8r_queue.sv
rtl/crc8r_back.sv
rtl/crc8_checked_packet_receiver.sv
bench/crc8_checked_packet_receiver_tb.sv
